@@ sv/wef_pkg.sv @@
// Shared types and constants of the weekly next-event finder.
package wef_pkg;

	localparam int NUM_EVENTS_DEF = 16;
	localparam int DAYS           = 7;
	localparam int HOUR_MIN       = 60;
	localparam int DAY_MIN        = 1440;
	localparam int WEEK_MIN       = 10080;
	localparam int HOUR_LAST      = 23;
	localparam int MINUTE_LAST    = 59;
	localparam int TIME_W         = 14;
	localparam int TOD_W          = 11;
	localparam int ENTRY_W        = 23;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		op_t        operation;
		logic [3:0] entry_index;
		logic [6:0] entry_days;
		logic [7:0] entry_hour;
		logic [7:0] entry_minute;
		logic [2:0] now_day;
		logic [4:0] now_hour;
		logic [5:0] now_minute;
	} cmd_t;

	typedef struct packed {
		logic       found;
		logic [3:0] event_index;
		logic [2:0] event_day;
		logic [4:0] event_hour;
		logic [5:0] event_minute;
	} rsp_t;

	typedef struct packed {
		logic [6:0] days;
		logic [7:0] hour;
		logic [7:0] minute;
	} entry_t;

endpackage

@@ sv/wef_ram.sv @@
// Generic single-port-write, registered-read RAM.
module wef_ram #(
	parameter int WIDTH = wef_pkg::ENTRY_W,
	parameter int DEPTH = wef_pkg::NUM_EVENTS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/weekly_next_event_finder_top.sv @@
// Weekly next-event finder: event table in RAM, scanned one entry per cycle per query.
// Writes may follow each other in every cycle while no query is in flight.
// A query keeps cmd_stall high through its scan until its result is loaded into rsp,
// so no command is taken meanwhile; the single RAM read port paces the scan.
// A query answered from a pending tie at the current time returns earlier in the scan.
// Reset clears the tie counter and the per-entry valid flags, so the table reads empty at once.
module weekly_next_event_finder_top #(
	parameter int NUM_EVENTS = wef_pkg::NUM_EVENTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  wef_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	output wef_pkg::rsp_t rsp,
	output logic          rsp_valid,
	input  logic          rsp_stall
);

	localparam int AW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
	localparam int TW = wef_pkg::TIME_W;
	localparam int DN = wef_pkg::DAYS;
	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_EVENTS - 1);
	localparam logic [TW-1:0] DAY_T    = TW'(wef_pkg::DAY_MIN);
	localparam logic [TW-1:0] WEEK_T   = TW'(wef_pkg::WEEK_MIN);
	localparam logic [TW-1:0] HOUR_T   = TW'(wef_pkg::HOUR_MIN);

	typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_SCAN, ST_DONE} state_t;

	state_t        state_q;
	logic          cmd_xfer;
	logic          wr_en;
	logic [AW+3:0] wr_ext;
	logic [AW-1:0] wr_addr;
	logic [NUM_EVENTS-1:0] ent_vld_q;

	logic [AW-1:0] scan_q;
	logic          issue_on_q;
	logic          issue;
	wef_pkg::entry_t rd_entry;
	wef_pkg::entry_t wr_entry;

	logic [2:0]    qday_q;
	logic [4:0]    qhour_q;
	logic [5:0]    qmin_q;
	logic [TW-1:0] now_raw;
	logic [TW-1:0] now_q;

	// Stage 1: RAM output.
	logic          v_s1, last_s1, vld_s1;
	logic [AW-1:0] idx_s1;
	// Stage 2: entry checked, time of day formed.
	logic          v_s2, last_s2;
	logic [AW-1:0] idx_s2;
	logic [6:0]    days_s2;
	logic [4:0]    hour_s2;
	logic [5:0]    min_s2;
	logic [wef_pkg::TOD_W-1:0] tod_s2;
	logic          entry_ok;
	// Stage 3: forward distance per weekday.
	logic          v_s3, last_s3;
	logic [AW-1:0] idx_s3;
	logic [4:0]    hour_s3;
	logic [5:0]    min_s3;
	logic [TW-1:0] dist_s3 [DN];
	logic [DN-1:0] pos_s3, zero_s3;
	logic [TW-1:0] dist_c [DN];
	logic [TW-1:0] ev_c [DN];
	// Stage 4: nearest later weekday of the entry and its match at the current time.
	logic          v_s4, last_s4;
	logic [AW-1:0] idx_s4;
	logic [4:0]    hour_s4;
	logic [5:0]    min_s4;
	logic          has_pos_s4, has_zero_s4;
	logic [TW-1:0] min_dist_s4;
	logic [2:0]    min_day_s4, zero_day_s4;
	logic          has_pos_c, has_zero_c;
	logic [TW-1:0] min_dist_c;
	logic [2:0]    min_day_c, zero_day_c;
	logic [AW+3:0] idx_ext;

	// Scan accumulators.
	logic [TW-1:0] best_q, best_n;
	logic [7:0]    ties_q, ties_n;
	logic          have_q, have_n;
	wef_pkg::rsp_t win_q, win_n, hit_res;
	logic [7:0]    at_now_q, at_now_n;
	logic [7:0]    pending_q;
	logic          acc, hit, finish;
	wef_pkg::rsp_t res_q, rsp_q;
	logic          rsp_valid_q;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_xfer  = cmd_valid & ~cmd_stall;
	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign wr_ext  = {AW'(0), cmd.entry_index};
	assign wr_addr = wr_ext[AW-1:0];
	assign wr_en   = cmd_xfer && (cmd.operation == wef_pkg::OP_WRITE)
		&& (32'(cmd.entry_index) < NUM_EVENTS);
	assign wr_entry = '{days: cmd.entry_days, hour: cmd.entry_hour, minute: cmd.entry_minute};

	assign issue = (state_q == ST_SCAN) && issue_on_q;

	wef_ram #(
		.WIDTH (wef_pkg::ENTRY_W),
		.DEPTH (NUM_EVENTS),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_entry),
		.re    (issue),
		.raddr (scan_q),
		.rdata (rd_entry)
	);

	// An entry never written reads as empty through its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (wr_en) begin
			ent_vld_q[wr_addr] <= 1'b1;
		end
	end

	assign now_raw = TW'(qday_q) * DAY_T + TW'(qhour_q) * HOUR_T + TW'(qmin_q);

	assign entry_ok = vld_s1 && (rd_entry.hour <= 8'(wef_pkg::HOUR_LAST))
		&& (rd_entry.minute <= 8'(wef_pkg::MINUTE_LAST));

	always_comb begin
		for (int d = 0; d < DN; d++) begin
			ev_c[d] = TW'(d * wef_pkg::DAY_MIN) + TW'(tod_s2);
			if (ev_c[d] >= now_q) begin
				dist_c[d] = ev_c[d] - now_q;
			end else begin
				dist_c[d] = WEEK_T - (now_q - ev_c[d]);
			end
		end
	end

	// Weekdays of one entry give distinct distances, so the first minimum is the only one.
	always_comb begin
		has_pos_c  = 1'b0;
		has_zero_c = 1'b0;
		min_dist_c = '0;
		min_day_c  = '0;
		zero_day_c = '0;
		for (int d = 0; d < DN; d++) begin
			if (pos_s3[d] && (!has_pos_c || dist_s3[d] < min_dist_c)) begin
				has_pos_c  = 1'b1;
				min_dist_c = dist_s3[d];
				min_day_c  = 3'(d);
			end
			if (zero_s3[d]) begin
				has_zero_c = 1'b1;
				zero_day_c = 3'(d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue & ~finish;
			v_s2 <= v_s1 & ~finish;
			v_s3 <= v_s2 & ~finish;
			v_s4 <= v_s3 & ~finish;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= scan_q;
		last_s1 <= (scan_q == LAST_IDX);
		vld_s1  <= ent_vld_q[scan_q];

		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		days_s2 <= entry_ok ? rd_entry.days : 7'd0;
		hour_s2 <= rd_entry.hour[4:0];
		min_s2  <= rd_entry.minute[5:0];
		tod_s2  <= wef_pkg::TOD_W'(rd_entry.hour[4:0]) * wef_pkg::TOD_W'(wef_pkg::HOUR_MIN)
			+ wef_pkg::TOD_W'(rd_entry.minute[5:0]);

		idx_s3  <= idx_s2;
		last_s3 <= last_s2;
		hour_s3 <= hour_s2;
		min_s3  <= min_s2;
		for (int d = 0; d < DN; d++) begin
			dist_s3[d] <= dist_c[d];
			pos_s3[d]  <= days_s2[d] && (dist_c[d] != '0);
			zero_s3[d] <= days_s2[d] && (dist_c[d] == '0);
		end

		idx_s4      <= idx_s3;
		last_s4     <= last_s3;
		hour_s4     <= hour_s3;
		min_s4      <= min_s3;
		has_pos_s4  <= has_pos_c;
		has_zero_s4 <= has_zero_c;
		min_dist_s4 <= min_dist_c;
		min_day_s4  <= min_day_c;
		zero_day_s4 <= zero_day_c;
	end

	assign idx_ext = {4'd0, idx_s4};
	assign acc     = v_s4 && (state_q == ST_SCAN);

	always_comb begin
		best_n   = best_q;
		ties_n   = ties_q;
		have_n   = have_q;
		win_n    = win_q;
		at_now_n = at_now_q;
		hit      = 1'b0;
		hit_res  = '{found: 1'b1, event_index: idx_ext[3:0], event_day: zero_day_s4,
			event_hour: hour_s4, event_minute: min_s4};
		if (acc) begin
			if (has_zero_s4) begin
				at_now_n = at_now_q + 8'd1;
				hit      = (at_now_n == pending_q);
			end
			if (has_pos_s4) begin
				if (!have_q || min_dist_s4 < best_q) begin
					best_n = min_dist_s4;
					ties_n = '0;
					have_n = 1'b1;
					win_n  = '{found: 1'b1, event_index: idx_ext[3:0], event_day: min_day_s4,
						event_hour: hour_s4, event_minute: min_s4};
				end else if (min_dist_s4 == best_q) begin
					ties_n            = ties_q + 8'd1;
					win_n.event_index = idx_ext[3:0];
				end
			end
		end
	end

	assign finish = acc && (hit || last_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			qday_q      <= '0;
			qhour_q     <= '0;
			qmin_q      <= '0;
			now_q       <= '0;
			scan_q      <= '0;
			issue_on_q  <= 1'b0;
			best_q      <= '0;
			ties_q      <= '0;
			have_q      <= 1'b0;
			win_q       <= '0;
			at_now_q    <= '0;
			pending_q   <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && (state_q != ST_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_xfer && cmd.operation == wef_pkg::OP_QUERY) begin
						qday_q  <= cmd.now_day;
						qhour_q <= cmd.now_hour;
						qmin_q  <= cmd.now_minute;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					now_q      <= (now_raw >= WEEK_T) ? (now_raw - WEEK_T) : now_raw;
					scan_q     <= '0;
					issue_on_q <= 1'b1;
					best_q     <= '0;
					ties_q     <= '0;
					have_q     <= 1'b0;
					win_q      <= '0;
					at_now_q   <= '0;
					state_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + AW'(1);
						if (scan_q == LAST_IDX) begin
							issue_on_q <= 1'b0;
						end
					end
					best_q   <= best_n;
					ties_q   <= ties_n;
					have_q   <= have_n;
					win_q    <= win_n;
					at_now_q <= at_now_n;
					if (hit) begin
						// An entry at the current time is handed out from the pending ties.
						res_q     <= hit_res;
						pending_q <= pending_q - 8'd1;
						state_q   <= ST_DONE;
					end else if (finish) begin
						if (pending_q == '0) begin
							pending_q <= ties_n;
						end
						res_q   <= have_n ? win_n : '0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ test/weekly_next_event_finder_top_tb.sv @@
// Self-checking testbench of the weekly next-event finder: directed table, then random traffic.
`timescale 1ns / 1ps

module weekly_next_event_finder_top_tb;

	localparam int NUM_EVENTS  = wef_pkg::NUM_EVENTS_DEF;
	localparam int N_ITEMS     = 700;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 2 * NUM_EVENTS + 10;
	localparam int CMD_W       = $bits(wef_pkg::cmd_t);

	typedef struct {
		wef_pkg::cmd_t c;
		bit            typed;
		wef_pkg::rsp_t want;
	} step_t;

	typedef struct {
		bit            typed;
		wef_pkg::rsp_t want;
	} pin_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	wef_pkg::cmd_t cmd = '0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	wef_pkg::rsp_t rsp;
	logic rsp_valid;
	logic rsp_stall = 1'b0;

	wef_pkg::entry_t sched_tbl [NUM_EVENTS];
	logic [7:0]      tie_backlog;
	wef_pkg::rsp_t   due_events [$];
	pin_t            typed_answers [$];
	step_t           steps [$];
	int              pool_hr [4];
	int              pool_mn [4];

	int          fails = 0;
	int          sent = 0;
	bit          idle_on = 1'b0;
	bit          hold_req = 1'b0;
	bit          hold_seen = 1'b0;
	int unsigned hold_left = 0;
	int unsigned burst_left = 0;

	weekly_next_event_finder_top #(
		.NUM_EVENTS(NUM_EVENTS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("weekly_next_event_finder_top_tb failed");
		$finish;
	end

	function automatic wef_pkg::cmd_t mk_write(input logic [3:0] idx, input logic [6:0] days,
			input logic [7:0] hr, input logic [7:0] mn);
		wef_pkg::cmd_t c;
		c = '0;
		c.operation    = wef_pkg::OP_WRITE;
		c.entry_index  = idx;
		c.entry_days   = days;
		c.entry_hour   = hr;
		c.entry_minute = mn;
		return c;
	endfunction

	function automatic wef_pkg::cmd_t mk_query(input logic [2:0] d, input logic [4:0] hr,
			input logic [5:0] mn);
		wef_pkg::cmd_t c;
		c = '0;
		c.operation  = wef_pkg::OP_QUERY;
		c.now_day    = d;
		c.now_hour   = hr;
		c.now_minute = mn;
		return c;
	endfunction

	function automatic wef_pkg::rsp_t mk_event(input logic [3:0] idx, input logic [2:0] d,
			input logic [4:0] hr, input logic [5:0] mn);
		return '{found: 1'b1, event_index: idx, event_day: d, event_hour: hr, event_minute: mn};
	endfunction

	// Query a few minutes ahead of one of the shared event times, on a chosen weekday.
	function automatic wef_pkg::cmd_t pool_query(input wef_pkg::cmd_t base, input int k,
			input int d, input int delta);
		wef_pkg::cmd_t c;
		int            tod;
		c = base;
		tod = pool_hr[k] * wef_pkg::HOUR_MIN + pool_mn[k];
		tod = (tod >= delta) ? tod - delta : 0;
		c.operation  = wef_pkg::OP_QUERY;
		c.now_day    = 3'(d);
		c.now_hour   = 5'(tod / wef_pkg::HOUR_MIN);
		c.now_minute = 6'(tod % wef_pkg::HOUR_MIN);
		return c;
	endfunction

	// Applies one accepted command to the table; returns 1 with the answer for a query.
	function automatic bit predict_next_event(input wef_pkg::cmd_t c, output wef_pkg::rsp_t r);
		int         now_min, ev, gap, best;
		logic [7:0] ties, hits;
		bit         done;
		r = '0;
		if (c.operation == wef_pkg::OP_WRITE) begin
			sched_tbl[c.entry_index] = '{days: c.entry_days, hour: c.entry_hour,
				minute: c.entry_minute};
			return 1'b0;
		end
		now_min = int'(c.now_day) * wef_pkg::DAY_MIN + int'(c.now_hour) * wef_pkg::HOUR_MIN
			+ int'(c.now_minute);
		if (now_min >= wef_pkg::WEEK_MIN)
			now_min -= wef_pkg::WEEK_MIN;
		best = 'hFFFF;
		ties = '0;
		hits = '0;
		done = 1'b0;
		for (int i = 0; i < NUM_EVENTS && !done; i++) begin
			if (sched_tbl[i].hour <= wef_pkg::HOUR_LAST
					&& sched_tbl[i].minute <= wef_pkg::MINUTE_LAST) begin
				for (int d = 0; d < wef_pkg::DAYS && !done; d++) begin
					if (sched_tbl[i].days[d]) begin
						ev = d * wef_pkg::DAY_MIN + int'(sched_tbl[i].hour) * wef_pkg::HOUR_MIN
							+ int'(sched_tbl[i].minute);
						gap = (ev < now_min) ? ev + wef_pkg::WEEK_MIN - now_min : ev - now_min;
						if (gap != 0) begin
							if (gap < best) begin
								ties = '0;
								best = gap;
								r = mk_event(4'(i), 3'(d), 5'(sched_tbl[i].hour),
									6'(sched_tbl[i].minute));
							end else if (gap == best) begin
								ties++;
								r.event_index = 4'(i);
							end
						end else begin
							// Events right at the current time come out only to work off a tie.
							hits++;
							if (hits == tie_backlog) begin
								tie_backlog--;
								r = mk_event(4'(i), 3'(d), 5'(sched_tbl[i].hour),
									6'(sched_tbl[i].minute));
								done = 1'b1;
							end
						end
					end
				end
			end
		end
		if (!done && tie_backlog == 0)
			tie_backlog = ties;
		return 1'b1;
	endfunction

	task automatic add_row(input wef_pkg::cmd_t c, input bit typed = 1'b0,
			input wef_pkg::rsp_t want = '0);
		steps.push_back('{c, typed, want});
	endtask

	task automatic send_cmd(input wef_pkg::cmd_t c, input bit typed = 1'b0,
			input wef_pkg::rsp_t want = '0);
		if (c.operation == wef_pkg::OP_QUERY)
			typed_answers.push_back('{typed, want});
		if (idle_on && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		sent++;
	endtask

	// Receiver side: short random stall bursts, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_req && !hold_seen) begin
			hold_seen <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (burst_left != 0) begin
			burst_left <= burst_left - 1;
			rsp_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			burst_left <= $urandom_range(0, 4);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		wef_pkg::rsp_t predicted;
		wef_pkg::rsp_t want;
		pin_t          pin;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (due_events.size() == 0) begin
					$error("result transfer with no query outstanding: %p", rsp);
					fails++;
				end else begin
					want = due_events.pop_front();
					if (rsp.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp.found);
						fails++;
					end
					if (rsp.event_index !== want.event_index) begin
						$error("event_index: expected %0d, got %0d",
							want.event_index, rsp.event_index);
						fails++;
					end
					if (rsp.event_day !== want.event_day) begin
						$error("event_day: expected %0d, got %0d",
							want.event_day, rsp.event_day);
						fails++;
					end
					if (rsp.event_hour !== want.event_hour) begin
						$error("event_hour: expected %0d, got %0d",
							want.event_hour, rsp.event_hour);
						fails++;
					end
					if (rsp.event_minute !== want.event_minute) begin
						$error("event_minute: expected %0d, got %0d",
							want.event_minute, rsp.event_minute);
						fails++;
					end
				end
			end
			if (cmd_valid && !cmd_stall) begin
				if (predict_next_event(cmd, predicted)) begin
					pin = typed_answers.pop_front();
					due_events.push_back(pin.typed ? pin.want : predicted);
				end
			end
		end
	end

	initial begin
		wef_pkg::cmd_t    c;
		logic [CMD_W-1:0] raw;
		int               pick, k, d, next_pool;

		foreach (sched_tbl[i])
			sched_tbl[i] = '0;
		tie_backlog = '0;

		add_row(mk_query(0, 0, 0), 1'b1, '0);
		add_row(mk_write(15, 7'h7F, 23, 59));
		add_row(mk_query(6, 23, 58), 1'b1, mk_event(15, 6, 23, 59));
		add_row(mk_query(6, 23, 59), 1'b1, mk_event(15, 0, 23, 59));
		// Out-of-range hour or minute leaves the entry unused.
		add_row(mk_write(0, 7'h7F, 24, 0));
		add_row(mk_write(1, 7'h7F, 0, 60));
		add_row(mk_write(3, 7'h7F, 8'hFF, 8'hFF));
		add_row(mk_query(0, 0, 0), 1'b1, mk_event(15, 0, 23, 59));
		// Raw current time past the week end wraps back by one week.
		add_row(mk_query(7, 31, 63), 1'b1, mk_event(15, 1, 23, 59));
		add_row(mk_query(7, 0, 0), 1'b1, mk_event(15, 0, 23, 59));
		// Three entries at the same time: handed out last index first.
		add_row(mk_write(4, 7'h04, 12, 30));
		add_row(mk_write(9, 7'h04, 12, 30));
		add_row(mk_write(12, 7'h04, 12, 30));
		add_row(mk_query(2, 12, 0));
		add_row(mk_query(2, 12, 30));
		add_row(mk_query(2, 12, 30));
		add_row(mk_query(2, 12, 30));
		add_row(mk_write(4, 7'h00, 12, 30));
		add_row(mk_write(0, 7'h7F, 0, 0));
		add_row(mk_query(6, 23, 59));
		add_row(mk_query(5, 0, 0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		idle_on <= 1'b1;
		@(posedge clk);

		foreach (steps[i])
			send_cmd(steps[i].c, steps[i].typed, steps[i].want);

		next_pool = 0;
		while (sent < N_ITEMS) begin
			if (sent >= next_pool) begin
				foreach (pool_hr[j]) begin
					pool_hr[j] = $urandom_range(0, 23);
					pool_mn[j] = $urandom_range(0, 59);
				end
				next_pool = sent + 100;
			end
			// Idle-free stretches: every fourth run of 50 commands, one during the long hold-off and one to close the run.
			idle_on <= (sent < 300 || sent >= 340) && sent < N_ITEMS - 100
				&& (sent / 50) % 4 != 3;
			if (sent >= 300 && !hold_req)
				hold_req <= 1'b1;

			pick = $urandom_range(0, 99);
			k = $urandom_range(0, 3);
			d = $urandom_range(0, 6);
			raw = CMD_W'({$urandom, $urandom});
			c = raw;
			if (pick < 30) begin
				c.operation    = wef_pkg::OP_WRITE;
				c.entry_days   = 7'($urandom_range(0, 127) & $urandom_range(0, 127));
				c.entry_hour   = 8'(pool_hr[k]);
				c.entry_minute = 8'(pool_mn[k]);
				send_cmd(c);
			end else if (pick < 38) begin
				c.operation = wef_pkg::OP_WRITE;
				send_cmd(c);
			end else if (pick < 45) begin
				c.operation    = wef_pkg::OP_WRITE;
				c.entry_hour   = 8'($urandom_range(0, 23));
				c.entry_minute = 8'($urandom_range(0, 59));
				send_cmd(c);
			end else if (pick < 70) begin
				send_cmd(pool_query(c, k, d, $urandom_range(0, 20)));
			end else if (pick < 80) begin
				// Set up a tie, then repeat the query at exactly that time to drain it.
				send_cmd(pool_query(c, k, d, $urandom_range(1, 20)));
				repeat ($urandom_range(1, 4))
					send_cmd(pool_query(c, k, d, 0));
			end else if (pick < 92) begin
				c.operation  = wef_pkg::OP_QUERY;
				c.now_day    = 3'($urandom_range(0, 6));
				c.now_hour   = 5'($urandom_range(0, 23));
				c.now_minute = 6'($urandom_range(0, 59));
				send_cmd(c);
			end else begin
				c.operation = wef_pkg::OP_QUERY;
				send_cmd(c);
			end
		end
		cmd_valid <= 1'b0;

		while (due_events.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fails == 0)
			$display("weekly_next_event_finder_top_tb passed");
		else
			$display("weekly_next_event_finder_top_tb failed");
		$finish;
	end

endmodule
